// ===== hdl/iso_ts_pkg.sv =====
// Shared constants, command type and calendar tables for the timestamp converter.
`default_nettype none

package iso_ts_pkg;

  // Text layout: YYYY-MM-DDTHH:MM:SSZ, positions counted from zero.
  localparam logic [4:0] TextLen   = 5'd20;
  localparam logic [4:0] PosDash1  = 5'd4;
  localparam logic [4:0] PosDash2  = 5'd7;
  localparam logic [4:0] PosTee    = 5'd10;
  localparam logic [4:0] PosColon1 = 5'd13;
  localparam logic [4:0] PosColon2 = 5'd16;
  localparam logic [4:0] PosZulu   = 5'd19;
  localparam logic [4:0] YearLast  = 5'd3;
  localparam logic [4:0] MonthLast = 5'd6;
  localparam logic [4:0] DayLast   = 5'd9;
  localparam logic [4:0] HourLast  = 5'd12;
  localparam logic [4:0] MinLast   = 5'd15;

  localparam logic [7:0] CharDash  = 8'h2D;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharTee   = 8'h54;
  localparam logic [7:0] CharZulu  = 8'h5A;
  localparam logic [7:0] CharZero  = 8'h30;
  localparam logic [7:0] CharNine  = 8'h39;
  localparam logic [7:0] CharNul   = 8'h00;

  localparam int unsigned SecsW = 39;

  typedef struct packed {
    logic take;      // a text byte is accepted this cycle
    logic clear;     // return the field gatherer to its reset values
    logic era_en;    // conversion step 1: 400-year era of the year
    logic yoe_en;    // step 2: year of era, day of year, range checks
    logic doe_en;    // step 3: day of era and time of day
    logic days_en;   // step 4: days relative to 1970-01-01
    logic secs_en;   // step 5: seconds
    logic load_out;  // move the result into the output register
  } iso_ts_cmd_t;

  // Days in a month of a common year; zero for a month number out of range.
  function automatic logic [6:0] days_in_month(input logic [6:0] m);
    logic [6:0] r;
    unique case (m)
      7'd1, 7'd3, 7'd5, 7'd7, 7'd8, 7'd10, 7'd12: r = 7'd31;
      7'd4, 7'd6, 7'd9, 7'd11:                    r = 7'd30;
      7'd2:                                       r = 7'd28;
      default:                                    r = 7'd0;
    endcase
    return r;
  endfunction

  // Day of a March-based year on which the month starts.
  function automatic logic [8:0] month_day_base(input logic [6:0] m);
    logic [8:0] r;
    unique case (m)
      7'd3:    r = 9'd0;
      7'd4:    r = 9'd31;
      7'd5:    r = 9'd61;
      7'd6:    r = 9'd92;
      7'd7:    r = 9'd122;
      7'd8:    r = 9'd153;
      7'd9:    r = 9'd184;
      7'd10:   r = 9'd214;
      7'd11:   r = 9'd245;
      7'd12:   r = 9'd275;
      7'd1:    r = 9'd306;
      7'd2:    r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/iso_ts_dp.sv =====
// Datapath: field gatherer, five-step date conversion and output register.
`default_nettype none

module iso_ts_dp
  import iso_ts_pkg::*;
(
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire iso_ts_cmd_t             cmd_i,
  input  wire logic [7:0]              text_byte_i,
  output logic                         date_ok_o,
  output logic signed [SecsW-1:0]      epoch_seconds_o
);

  // Field gatherer state.
  logic [4:0]  pos_q, pos_d;
  logic        ended_q, ended_d;
  logic        err_q, err_d;
  logic [13:0] year_q, year_d;
  logic [6:0]  month_q, month_d;
  logic [6:0]  day_q, day_d;
  logic [6:0]  hour_q, hour_d;
  logic [6:0]  min_q, min_d;
  logic [6:0]  sec_q, sec_d;

  logic       is_digit;
  logic [6:0] digit;

  assign is_digit = (text_byte_i >= CharZero) && (text_byte_i <= CharNine);
  assign digit    = {3'd0, text_byte_i[3:0]};

  always_comb begin
    pos_d   = pos_q;
    ended_d = ended_q;
    err_d   = err_q;
    year_d  = year_q;
    month_d = month_q;
    day_d   = day_q;
    hour_d  = hour_q;
    min_d   = min_q;
    sec_d   = sec_q;
    if (cmd_i.clear) begin
      pos_d   = 5'd0;
      ended_d = 1'b0;
      err_d   = 1'b0;
      year_d  = 14'd0;
      month_d = 7'd0;
      day_d   = 7'd0;
      hour_d  = 7'd0;
      min_d   = 7'd0;
      sec_d   = 7'd0;
    end else if (cmd_i.take) begin
      if (!ended_q && !err_q) begin
        if (pos_q < TextLen) begin
          priority if (pos_q == PosDash1 || pos_q == PosDash2) begin
            if (text_byte_i != CharDash) err_d = 1'b1;
          end else if (pos_q == PosColon1 || pos_q == PosColon2) begin
            if (text_byte_i != CharColon) err_d = 1'b1;
          end else if (pos_q == PosTee) begin
            if (text_byte_i != CharTee) err_d = 1'b1;
          end else if (pos_q == PosZulu) begin
            if (text_byte_i != CharZulu) err_d = 1'b1;
          end else if (!is_digit) begin
            err_d = 1'b1;
          end else if (pos_q <= YearLast) begin
            year_d = year_q * 14'd10 + {7'd0, digit};
          end else if (pos_q <= MonthLast) begin
            month_d = month_q * 7'd10 + digit;
          end else if (pos_q <= DayLast) begin
            day_d = day_q * 7'd10 + digit;
          end else if (pos_q <= HourLast) begin
            hour_d = hour_q * 7'd10 + digit;
          end else if (pos_q <= MinLast) begin
            min_d = min_q * 7'd10 + digit;
          end else begin
            sec_d = sec_q * 7'd10 + digit;
          end
        end else if (text_byte_i == CharNul) begin
          ended_d = 1'b1;
        end else begin
          err_d = 1'b1;
        end
      end
      if (pos_q < TextLen) pos_d = pos_q + 5'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q   <= 5'd0;
      ended_q <= 1'b0;
      err_q   <= 1'b0;
      year_q  <= 14'd0;
      month_q <= 7'd0;
      day_q   <= 7'd0;
      hour_q  <= 7'd0;
      min_q   <= 7'd0;
      sec_q   <= 7'd0;
    end else begin
      pos_q   <= pos_d;
      ended_q <= ended_d;
      err_q   <= err_d;
      year_q  <= year_d;
      month_q <= month_d;
      day_q   <= day_d;
      hour_q  <= hour_d;
      min_q   <= min_d;
      sec_q   <= sec_d;
    end
  end

  // Step 1: era of the year, floor(year / 400) by reciprocal multiply.
  logic [4:0]  era_q;
  logic [26:0] era_prod;

  assign era_prod = {13'd0, year_q} * 27'd5243;

  always_ff @(posedge clk_i) begin
    if (cmd_i.era_en) era_q <= era_prod[25:21];
  end

  // Step 2: year of era shifted to a March-based year, range checks.
  logic [13:0]       rem_full;
  logic [8:0]        rem;
  logic              leap, early, ok_d;
  logic [6:0]        day_lim;
  logic [8:0]        yoe_d, doy_d;
  logic signed [5:0] era_s_d;
  logic [8:0]        yoe_q, doy_q;
  logic signed [5:0] era_s_q;
  logic              ok_q;

  always_comb begin
    rem_full = year_q - {9'd0, era_q} * 14'd400;
    rem      = rem_full[8:0];
    // Year mod 400 settles the century rules; year mod 4 is its low bits.
    leap     = (year_q[1:0] == 2'd0) && (rem != 9'd100) && (rem != 9'd200)
               && (rem != 9'd300);
    day_lim  = days_in_month(month_q) + {6'd0, (month_q == 7'd2) && leap};
    ok_d     = !err_q && (pos_q == TextLen)
               && (month_q >= 7'd1) && (month_q <= 7'd12)
               && (hour_q <= 7'd23) && (min_q <= 7'd59) && (sec_q <= 7'd59)
               && (day_q >= 7'd1) && (day_q <= day_lim);
    early    = (month_q <= 7'd2);
    era_s_d  = $signed({1'b0, era_q});
    yoe_d    = rem;
    if (early) begin
      if (rem == 9'd0) begin
        yoe_d   = 9'd399;
        era_s_d = $signed({1'b0, era_q}) - 6'sd1;
      end else begin
        yoe_d = rem - 9'd1;
      end
    end
    doy_d = month_day_base(month_q) + {2'd0, day_q} - 9'd1;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.yoe_en) begin
      yoe_q   <= yoe_d;
      doy_q   <= doy_d;
      era_s_q <= era_s_d;
      ok_q    <= ok_d;
    end
  end

  // Step 3: day of era and seconds into the day.
  logic [14:0] q100_prod;
  logic [17:0] doe_d, doe_q;
  logic [16:0] tod_d, tod_q;

  assign q100_prod = {6'd0, yoe_q} * 15'd41;
  assign doe_d = {9'd0, yoe_q} * 18'd365 + {11'd0, yoe_q[8:2]}
                 - {16'd0, q100_prod[13:12]} + {9'd0, doy_q};
  assign tod_d = {10'd0, hour_q} * 17'd3600 + {10'd0, min_q} * 17'd60
                 + {10'd0, sec_q};

  always_ff @(posedge clk_i) begin
    if (cmd_i.doe_en) begin
      doe_q <= doe_d;
      tod_q <= tod_d;
    end
  end

  // Step 4: days since 1970-01-01.
  logic signed [23:0] era_x, days_d, days_q;

  assign era_x  = $signed({{18{era_s_q[5]}}, era_s_q});
  assign days_d = era_x * 24'sd146097 + $signed({6'd0, doe_q}) - 24'sd719468;

  always_ff @(posedge clk_i) begin
    if (cmd_i.days_en) days_q <= days_d;
  end

  // Step 5: seconds, kept to the 39-bit two's complement result.
  logic signed [SecsW-1:0] days_w, secs_d, secs_q;

  assign days_w = $signed({{(SecsW-24){days_q[23]}}, days_q});
  assign secs_d = days_w * 39'sd86400 + $signed({22'd0, tod_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.secs_en) secs_q <= secs_d;
  end

  // Output register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      date_ok_o       <= ok_q;
      epoch_seconds_o <= ok_q ? secs_q : '0;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/iso_ts_ctrl.sv =====
// Controller: request handshakes and sequencing of the conversion steps.
`default_nettype none

module iso_ts_ctrl
  import iso_ts_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  in_valid_i,
  output logic       in_ready_o,
  input  wire logic  end_of_text_i,
  output logic       out_valid_o,
  input  wire logic  out_ready_i,
  output iso_ts_cmd_t cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ERA  = 3'd1;
  localparam logic [2:0] S_YOE  = 3'd2;
  localparam logic [2:0] S_DOE  = 3'd3;
  localparam logic [2:0] S_DAYS = 3'd4;
  localparam logic [2:0] S_SECS = 3'd5;
  localparam logic [2:0] S_OUT  = 3'd6;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       in_fire;

  assign in_ready_o  = (state_q == S_IDLE);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        cmd_o.take = in_fire;
        if (in_fire && end_of_text_i) state_d = S_ERA;
      end
      S_ERA: begin
        cmd_o.era_en = 1'b1;
        state_d      = S_YOE;
      end
      S_YOE: begin
        cmd_o.yoe_en = 1'b1;
        state_d      = S_DOE;
      end
      S_DOE: begin
        cmd_o.doe_en = 1'b1;
        state_d      = S_DAYS;
      end
      S_DAYS: begin
        cmd_o.days_en = 1'b1;
        state_d       = S_SECS;
      end
      S_SECS: begin
        cmd_o.secs_en = 1'b1;
        cmd_o.clear   = 1'b1;
        state_d       = S_OUT;
      end
      S_OUT: begin
        if (!out_valid_q || out_ready_i) begin
          cmd_o.load_out = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.load_out) begin
      out_valid_d = 1'b1;
    end else if (out_valid_q && out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

`ifndef ASSERT_OFF
  a_last_starts_conv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && end_of_text_i) |=> (state_q == S_ERA))
    else $error("last byte did not start the conversion");

  a_valid_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_OUT))
    else $error("result shown without passing the output step");

  a_out_waits: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("pending result overwritten");

  a_clear_then_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clear |=> (state_q == S_OUT))
    else $error("gatherer cleared outside the final step");
`endif

endmodule

`default_nettype wire

// ===== hdl/iso_timestamp_to_epoch_seconds.sv =====
// Top level: ISO 8601 UTC timestamp text to signed Unix seconds.
// Input: a byte without the end mark is taken while idle; the byte with the end mark starts a
// five-step conversion; no further byte is taken until the output register is loaded.
// Output: out_valid_o rises after the request carrying the end mark is accepted, once the
// five sequenced conversion steps have run and the output register has been loaded.
// Reset: rst_ni is asynchronous, active low; it empties the output and clears the gatherer.
`default_nettype none

module iso_timestamp_to_epoch_seconds
  import iso_ts_pkg::*;
(
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  // Input request: one text byte with its end mark.
  input  wire logic                in_valid_i,
  output logic                     in_ready_o,
  input  wire logic [7:0]          text_byte_i,
  input  wire logic                end_of_text_i,
  // Output request: one result per text.
  output logic                     out_valid_o,
  input  wire logic                out_ready_i,
  output logic                     date_ok_o,
  output logic signed [SecsW-1:0]  epoch_seconds_o
);

  // The controller accepts bytes while idle and walks the datapath through
  // era, year-of-era, day-of-era, day count and seconds once the final byte
  // has been taken. The output register decouples the sink: further bytes of
  // the next text are taken while a finished result waits to be collected.
  iso_ts_cmd_t cmd;

  iso_ts_ctrl u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .end_of_text_i(end_of_text_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .cmd_o        (cmd)
  );

  // The datapath holds the gathered fields, checks their ranges (including
  // the Gregorian leap day) and converts the date with the days-from-civil
  // method; the seconds are forced to zero when the text is not valid.
  iso_ts_dp u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .text_byte_i    (text_byte_i),
    .date_ok_o      (date_ok_o),
    .epoch_seconds_o(epoch_seconds_o)
  );

endmodule

`default_nettype wire
